@@ sv/assert_macros.svh @@
// Assertion macros used by the queue core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
// Implication checked in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`endif

@@ sv/dswq_pkg.sv @@
// Types and constants for the deadline sorted wait queue.
package dswq_pkg;
  typedef enum logic [1:0] {
    ACT_WAIT  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_WAKE  = 2'd2,
    ACT_PURGE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_TIMEOUT = 2'd0,
    KIND_FUTEX   = 2'd1
  } wait_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_WAIT = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_EMIT,
    S_SUMMARY
  } state_t;

  localparam logic [63:0] ALL_ONES = '1;
endpackage

@@ sv/deadline_sorted_wait_queue_core.sv @@
// Top level of the deadline sorted wait queue: a sequencer over entry registers.
// One word is accepted when in_stall is low; the block then walks its entries one slot per
// cycle with a single compare unit, removes an entry by shifting the tail down one slot per
// cycle, and inserts a wait by shifting the tail up. A tick, wake or purge emits one result
// word per removed entry and then a summary word; a wait emits only the summary. in_stall
// stays high until the summary word is loaded, so no new word is accepted before the last
// one is done. The output register holds one result word.
`include "assert_macros.svh"
module deadline_sorted_wait_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [63:0] now_ms,
  input  logic [15:0] thread_id,
  input  logic [15:0] process_id,
  input  logic [1:0]  wait_kind,
  input  logic [63:0] object_id,
  input  logic [31:0] time_or_limit,
  input  logic        futex_mapped,
  input  logic        futex_kernel_flag,
  input  logic [30:0] futex_lock_value,
  input  logic        compare_not_equal,
  input  logic [30:0] compare_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [15:0] woken_thread,
  output logic [1:0]  status,
  output logic [4:0]  woken_count,
  output logic [4:0]  occupancy,
  output logic        ready_res,
  output logic        last
);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  dswq_pkg::state_t state, state_next;

  logic [15:0] e_thread  [QUEUE_DEPTH];
  logic [15:0] e_process [QUEUE_DEPTH];
  logic        e_kind    [QUEUE_DEPTH];
  logic [63:0] e_object  [QUEUE_DEPTH];
  logic [63:0] e_dead    [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] entry_valid;
  logic [CW-1:0] entry_count;

  // Latched request.
  logic [1:0]  act;
  logic [63:0] now_r;
  logic [15:0] thr_r, proc_r;
  logic        kind_r;
  logic [63:0] obj_r, dl_r;
  logic [31:0] limit_r;
  logic        enable_r;
  logic [1:0]  status_r;
  logic [4:0]  woken;

  // Scan cursor and shift cursor.
  logic [CW-1:0] pos;
  logic [CW-1:0] sh;
  logic [15:0]   emit_thr;

  logic        cmp_hit, take;
  logic [IW-1:0] pidx;
  logic [63:0]   head;

  assign pidx = pos[IW-1:0];
  assign in_stall = (state != dswq_pkg::S_IDLE);

  wire accept = in_valid && !in_stall;
  wire cmp_ok = compare_not_equal ? (futex_lock_value != compare_value)
                                  : (futex_lock_value == compare_value);
  wire out_free = !out_valid || !out_stall;
  // The word being emitted counts toward the limit.
  wire limit_hit = (limit_r != 32'd0) && (({27'd0, woken} + 32'd1) >= limit_r);
  wire out_load = out_free && (state == dswq_pkg::S_EMIT || state == dswq_pkg::S_SUMMARY);

  // Shared compare for the slot under the cursor.
  always_comb begin
    cmp_hit = 1'b0;
    unique case (dswq_pkg::action_t'(act))
      dswq_pkg::ACT_WAIT:  cmp_hit = e_dead[pidx] > dl_r;
      dswq_pkg::ACT_TICK:  cmp_hit = e_dead[pidx] <= now_r;
      dswq_pkg::ACT_WAKE:  cmp_hit = e_kind[pidx] && (e_object[pidx] == obj_r) &&
                                     (e_process[pidx] == proc_r);
      dswq_pkg::ACT_PURGE: cmp_hit = e_process[pidx] == proc_r;
      default:             cmp_hit = 1'b0;
    endcase
  end

  assign take = (pos < entry_count) && cmp_hit;
  assign head = (entry_count != '0) ? e_dead[0] : dswq_pkg::ALL_ONES;

  always_comb begin
    state_next = state;
    unique case (state)
      dswq_pkg::S_IDLE: begin
        if (accept) state_next = dswq_pkg::S_SCAN;
      end
      dswq_pkg::S_SCAN: begin
        if (act == dswq_pkg::ACT_WAIT) begin
          if (!enable_r || take || pos >= entry_count) state_next = dswq_pkg::S_SHIFT;
        end else if (!enable_r || pos >= entry_count) begin
          state_next = dswq_pkg::S_SUMMARY;
        end else if (take) begin
          state_next = dswq_pkg::S_SHIFT;
        end else if (act == dswq_pkg::ACT_TICK) begin
          state_next = dswq_pkg::S_SUMMARY;
        end
      end
      dswq_pkg::S_SHIFT: begin
        if (act == dswq_pkg::ACT_WAIT) begin
          if (!enable_r || sh == pos) state_next = dswq_pkg::S_SUMMARY;
        end else if (sh + 1'b1 >= entry_count) begin
          state_next = dswq_pkg::S_EMIT;
        end
      end
      dswq_pkg::S_EMIT: begin
        if (out_free) begin
          if (limit_hit && act == dswq_pkg::ACT_WAKE) state_next = dswq_pkg::S_SUMMARY;
          else state_next = dswq_pkg::S_SCAN;
        end
      end
      dswq_pkg::S_SUMMARY: begin
        if (out_free) state_next = dswq_pkg::S_IDLE;
      end
      default: state_next = dswq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= dswq_pkg::S_IDLE;
    else     state <= state_next;
  end

  logic [IW-1:0] sidx, sidx_m1, sidx_p1;
  assign sidx = sh[IW-1:0];
  assign sidx_m1 = IW'(sh - 1'b1);
  assign sidx_p1 = IW'(sh + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      entry_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        dswq_pkg::S_IDLE: begin
          if (accept) begin
            act     <= action;
            now_r   <= now_ms;
            thr_r   <= thread_id;
            proc_r  <= process_id;
            kind_r  <= wait_kind[0];
            obj_r   <= (wait_kind == dswq_pkg::KIND_TIMEOUT) ? {48'd0, thread_id} : object_id;
            dl_r    <= (time_or_limit != 32'd0) ? now_ms + {32'd0, time_or_limit}
                                                : dswq_pkg::ALL_ONES;
            limit_r <= time_or_limit;
            woken   <= '0;
            pos     <= '0;
            status_r <= dswq_pkg::ST_OK;
            enable_r <= 1'b1;
            if (action == dswq_pkg::ACT_WAIT) begin
              if (wait_kind == dswq_pkg::KIND_TIMEOUT ||
                  (wait_kind == dswq_pkg::KIND_FUTEX && futex_mapped &&
                   futex_kernel_flag && cmp_ok)) begin
                if (entry_count >= CW'(QUEUE_DEPTH)) begin
                  status_r <= dswq_pkg::ST_FULL;
                  enable_r <= 1'b0;
                end
              end else begin
                status_r <= dswq_pkg::ST_NOT_WAIT;
                enable_r <= 1'b0;
              end
            end else if (action == dswq_pkg::ACT_WAKE) begin
              enable_r <= (wait_kind == dswq_pkg::KIND_FUTEX) && futex_mapped &&
                          !futex_kernel_flag && cmp_ok;
            end
          end
        end
        dswq_pkg::S_SCAN: begin
          if (act == dswq_pkg::ACT_WAIT) begin
            // The insert slot is the first entry with a later deadline.
            if (enable_r && (take || pos >= entry_count)) sh <= entry_count;
            else if (enable_r) pos <= pos + 1'b1;
          end else if (enable_r && take) begin
            emit_thr <= e_thread[pidx];
            sh <= pos;
          end else if (enable_r && pos < entry_count) begin
            pos <= pos + 1'b1;
          end
        end
        dswq_pkg::S_SHIFT: begin
          if (act == dswq_pkg::ACT_WAIT) begin
            if (enable_r) begin
              if (sh == pos) begin
                e_thread[sidx]  <= thr_r;
                e_process[sidx] <= proc_r;
                e_kind[sidx]    <= kind_r;
                e_object[sidx]  <= obj_r;
                e_dead[sidx]    <= dl_r;
                entry_valid[IW'(entry_count)] <= 1'b1;
                entry_count <= entry_count + 1'b1;
              end else begin
                e_thread[sidx]  <= e_thread[sidx_m1];
                e_process[sidx] <= e_process[sidx_m1];
                e_kind[sidx]    <= e_kind[sidx_m1];
                e_object[sidx]  <= e_object[sidx_m1];
                e_dead[sidx]    <= e_dead[sidx_m1];
                sh <= sh - 1'b1;
              end
            end
          end else if (sh + 1'b1 >= entry_count) begin
            entry_count <= entry_count - 1'b1;
            entry_valid[IW'(entry_count - 1'b1)] <= 1'b0;
          end else begin
            e_thread[sidx]  <= e_thread[sidx_p1];
            e_process[sidx] <= e_process[sidx_p1];
            e_kind[sidx]    <= e_kind[sidx_p1];
            e_object[sidx]  <= e_object[sidx_p1];
            e_dead[sidx]    <= e_dead[sidx_p1];
            sh <= sh + 1'b1;
          end
        end
        dswq_pkg::S_EMIT: begin
          if (out_free) begin
            result_kind  <= 1'b1;
            woken_thread <= emit_thr;
            status       <= dswq_pkg::ST_OK;
            woken_count  <= '0;
            occupancy    <= '0;
            ready_res    <= 1'b0;
            last         <= 1'b0;
            woken        <= woken + 1'b1;
          end
        end
        dswq_pkg::S_SUMMARY: begin
          if (out_free) begin
            result_kind  <= 1'b0;
            woken_thread <= '0;
            status       <= status_r;
            woken_count  <= woken;
            occupancy    <= 5'(entry_count);
            ready_res    <= now_r >= head;
            last         <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_count_max, clk, rst, 1'b1, entry_count <= CW'(QUEUE_DEPTH), "count overflow")
  `ASSERT_IMPL(a_valid_cnt, clk, rst, 1'b1, $countones(entry_valid) == int'(entry_count), "valid bits disagree with count")
  `ASSERT_IMPL(a_idle_out, clk, rst, state == dswq_pkg::S_IDLE && out_valid, last, "only summary may wait at idle")
  `ASSERT_NEXT(a_accept, clk, rst, accept, state == dswq_pkg::S_SCAN, "accepted word not scanned")
endmodule
